[rtl/pahs_pkg.sv]
`default_nettype none

package pahs_pkg;

  localparam logic [1:0] STAGE_FAST  = 2'd0;
  localparam logic [1:0] STAGE_SLOW  = 2'd1;
  localparam logic [1:0] STAGE_HOMED = 2'd2;

  localparam logic [1:0] REG_USE_SECOND_X = 2'd0;
  localparam logic [1:0] REG_X_MAX        = 2'd1;
  localparam logic [1:0] REG_Y_MAX        = 2'd2;
  localparam logic [1:0] REG_HOMED_SPEED  = 2'd3;

  localparam logic [7:0] BACKOFF_END = 8'd50;
  localparam logic [7:0] SEEK_END    = 8'd240;
  localparam logic [7:0] CLEAR_END   = 8'd250;

  localparam logic [31:0] FAST_POS      = 32'd1000;
  localparam logic [31:0] SPEED_BACKOFF = 32'h0000_4000;
  localparam logic [31:0] SPEED_SEEK    = 32'h0000_0200;
  localparam logic [31:0] SPEED_CLEAR   = 32'h0000_0040;

  typedef struct packed {
    logic       use_second_x;
    logic [31:0] x_max;
    logic [31:0] y_max;
    logic [31:0] homed_speed;
  } cfg_t;

  typedef struct packed {
    logic x;
    logic x2;
    logic y;
  } switches_t;

  // flags: bit 0 x, bit 1 second x, bit 2 y; dirs: bit 0 x away, bit 1 y away
  typedef struct packed {
    logic [2:0] flags;
    logic [1:0] stage;
    logic [7:0] count;
    logic [1:0] dirs;
  } state_t;

  typedef struct packed {
    logic        step_x;
    logic        step_x2;
    logic        step_y;
    logic        dir_x_away;
    logic        dir_y_away;
    logic        speed_load;
    logic [31:0] speed;
    logic        position_load;
    logic [31:0] new_pos_x;
    logic [31:0] new_pos_y;
    logic [1:0]  stage;
  } result_t;

endpackage

`default_nettype wire

[rtl/pahs_step.sv]
`default_nettype none

module pahs_step (
  input  pahs_pkg::cfg_t      cfg,
  input  pahs_pkg::state_t    st,
  input  pahs_pkg::switches_t sw,
  output pahs_pkg::state_t    st_next,
  output pahs_pkg::result_t   res
);

  logic two;
  logic all_fast;
  logic all_seek;

  assign two      = cfg.use_second_x;
  assign all_fast = st.flags[0] && st.flags[2] && sw.x && sw.y &&
                    (!two || (st.flags[1] && sw.x2));
  assign all_seek = sw.x && sw.y && (!two || sw.x2);

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (st.stage)
      pahs_pkg::STAGE_FAST: begin
        res.position_load = 1'b1;
        res.new_pos_x     = pahs_pkg::FAST_POS;
        res.new_pos_y     = pahs_pkg::FAST_POS;
        if (all_fast) begin
          st_next.stage = pahs_pkg::STAGE_SLOW;
          st_next.count = '0;
        end else begin
          res.step_x = !sw.x;
          if (!sw.x) begin
            st_next.dirs[0] = 1'b0;
          end else begin
            st_next.flags[0] = 1'b1;
          end
          if (two) begin
            res.step_x2 = !sw.x2;
            if (!sw.x2) begin
              st_next.dirs[0] = 1'b0;
            end else begin
              st_next.flags[1] = 1'b1;
            end
          end
          res.step_y = !sw.y;
          if (!sw.y) begin
            st_next.dirs[1] = 1'b0;
          end else begin
            st_next.flags[2] = 1'b1;
          end
        end
      end
      pahs_pkg::STAGE_SLOW: begin
        st_next.dirs   = 2'b11;
        res.speed_load = 1'b1;
        if (st.count < pahs_pkg::BACKOFF_END) begin
          res.speed     = pahs_pkg::SPEED_BACKOFF;
          st_next.count = st.count + 8'd1;
          res.step_x    = 1'b1;
          res.step_x2   = two;
          res.step_y    = 1'b1;
        end else if (st.count < pahs_pkg::SEEK_END) begin
          res.speed       = pahs_pkg::SPEED_SEEK;
          res.step_x      = !sw.x;
          res.step_x2     = two && !sw.x2;
          res.step_y      = !sw.y;
          st_next.dirs[0] = sw.x && !(two && !sw.x2);
          st_next.dirs[1] = sw.y;
          if (all_seek) begin
            st_next.count = pahs_pkg::SEEK_END;
          end
        end else if (st.count < pahs_pkg::CLEAR_END) begin
          res.speed     = pahs_pkg::SPEED_CLEAR;
          st_next.count = st.count + 8'd1;
          res.step_x    = 1'b1;
          res.step_x2   = two;
          res.step_y    = 1'b1;
        end else begin
          res.speed         = cfg.homed_speed;
          res.position_load = 1'b1;
          res.new_pos_x     = cfg.x_max;
          res.new_pos_y     = cfg.y_max;
          st_next.stage     = pahs_pkg::STAGE_HOMED;
        end
      end
      default: begin
      end
    endcase
    res.dir_x_away = st_next.dirs[0];
    res.dir_y_away = st_next.dirs[1];
    res.stage      = st_next.stage;
  end

endmodule

`default_nettype wire

[rtl/plotter_axis_homing_sequencer_unit.sv]
// Homing sequencer for a plotter's X, optional second X and Y axes. Each input
// word is one motor timer tick carrying the home switch levels; each tick gives
// exactly one result word with step requests, directions, optional speed and
// position loads, and the stage (0 fast seek, 1 slow refine, 2 homed). One word
// is taken every clock cycle unless a stalled result word holds the flow; each
// word is captured in the input register and its result, from a single pass of
// decision logic, in the result register. Registers are written through cfg_we/
// cfg_index/cfg_data and act on the ticks that follow. After homing the block
// idles until reset.
`default_nettype none

module plotter_axis_homing_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        x_at_home,
  input  wire logic        x2_at_home,
  input  wire logic        y_at_home,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             step_x,
  output logic             step_x2,
  output logic             step_y,
  output logic             dir_x_away,
  output logic             dir_y_away,
  output logic             speed_load,
  output logic [31:0]      speed,
  output logic             position_load,
  output logic [31:0]      new_pos_x,
  output logic [31:0]      new_pos_y,
  output logic [1:0]       stage,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  pahs_pkg::cfg_t      cfg;
  pahs_pkg::state_t    st;
  pahs_pkg::state_t    st_next;
  pahs_pkg::switches_t sw;
  pahs_pkg::result_t   res_next;
  pahs_pkg::result_t   res;
  logic                sw_valid;
  logic                out_free;
  logic                adv;

  assign out_free = !out_valid || out_ready;
  assign adv      = sw_valid && out_free;
  assign in_ready = !sw_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pahs_pkg::REG_USE_SECOND_X: cfg.use_second_x <= cfg_data[0];
        pahs_pkg::REG_X_MAX:        cfg.x_max        <= cfg_data;
        pahs_pkg::REG_Y_MAX:        cfg.y_max        <= cfg_data;
        pahs_pkg::REG_HOMED_SPEED:  cfg.homed_speed  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_valid <= 1'b0;
    end else if (in_ready) begin
      sw_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      sw <= '{x: x_at_home, x2: x2_at_home, y: y_at_home};
    end
  end

  pahs_step u_step (
    .cfg     (cfg),
    .st      (st),
    .sw      (sw),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        st <= st_next;
      end
      if (out_free) begin
        out_valid <= sw_valid;
      end
    end
    if (adv) begin
      res <= res_next;
    end
  end

  assign step_x        = res.step_x;
  assign step_x2       = res.step_x2;
  assign step_y        = res.step_y;
  assign dir_x_away    = res.dir_x_away;
  assign dir_y_away    = res.dir_y_away;
  assign speed_load    = res.speed_load;
  assign speed         = res.speed;
  assign position_load = res.position_load;
  assign new_pos_x     = res.new_pos_x;
  assign new_pos_y     = res.new_pos_y;
  assign stage         = res.stage;

endmodule

`default_nettype wire

[rtl/pahs_checker.sv]
`default_nettype none

module pahs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        step_x,
  input wire logic        step_x2,
  input wire logic        step_y,
  input wire logic        speed_load,
  input wire logic [31:0] speed,
  input wire logic        position_load,
  input wire logic [31:0] new_pos_x,
  input wire logic [31:0] new_pos_y,
  input wire logic [1:0]  stage
);

  // stalled word holds its stage and speed
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stage) && $stable(speed))
    else $error("result word changed while stalled");

  // homed words without a speed load carry no steps and no position load
  a_homed_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && stage == pahs_pkg::STAGE_HOMED && !speed_load |->
      !step_x && !step_x2 && !step_y && !position_load)
    else $error("step or load in homed stage");

  // speed loads only come from the slow stage
  a_speed_stage: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed_load |-> stage != pahs_pkg::STAGE_FAST)
    else $error("speed load during fast seek");

  // unloaded fields read zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_load || speed == 32'd0) &&
      (position_load || (new_pos_x == 32'd0 && new_pos_y == 32'd0)))
    else $error("nonzero field without load");

  a_no_code3: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stage <= pahs_pkg::STAGE_HOMED)
    else $error("unused stage code");

endmodule

bind plotter_axis_homing_sequencer_unit pahs_checker u_pahs_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        x_at_home = 1'b0;
  logic        x2_at_home = 1'b0;
  logic        y_at_home = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        step_x;
  logic        step_x2;
  logic        step_y;
  logic        dir_x_away;
  logic        dir_y_away;
  logic        speed_load;
  logic [31:0] speed;
  logic        position_load;
  logic [31:0] new_pos_x;
  logic [31:0] new_pos_y;
  logic [1:0]  stage;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  plotter_axis_homing_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .x_at_home(x_at_home),
    .x2_at_home(x2_at_home),
    .y_at_home(y_at_home),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .step_x(step_x),
    .step_x2(step_x2),
    .step_y(step_y),
    .dir_x_away(dir_x_away),
    .dir_y_away(dir_y_away),
    .speed_load(speed_load),
    .speed(speed),
    .position_load(position_load),
    .new_pos_x(new_pos_x),
    .new_pos_y(new_pos_y),
    .stage(stage),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // shadow of the homing state and registers
  logic        two_x;
  logic [31:0] xmax_cfg;
  logic [31:0] ymax_cfg;
  logic [31:0] speed_cfg;
  logic [2:0]  found_axes;
  logic [1:0]  home_stage;
  logic [7:0]  refine_count;
  logic [1:0]  away_dirs;

  pahs_pkg::result_t tick_results_q[$];
  int      stage_ticks[4];
  int      sent_ticks;
  int      checked_words;
  int      errors;
  int      burst_left;
  int      idle_cycles;
  int      rx_cycle;
  int      hold_left;
  bit      hold_req;

  // true when this switch word would end the current search
  function automatic bit ends_search(pahs_pkg::switches_t sw);
    if (home_stage == pahs_pkg::STAGE_FAST)
      return found_axes[0] && found_axes[2] && sw.x && sw.y &&
             (!two_x || (found_axes[1] && sw.x2));
    return sw.x && sw.y && (!two_x || sw.x2);
  endfunction

  task automatic advance_homing(input pahs_pkg::switches_t sw, output pahs_pkg::result_t r);
    r = '0;
    stage_ticks[home_stage]++;
    case (home_stage)
      pahs_pkg::STAGE_FAST: begin
        r.position_load = 1'b1;
        r.new_pos_x = pahs_pkg::FAST_POS;
        r.new_pos_y = pahs_pkg::FAST_POS;
        if (ends_search(sw)) begin
          home_stage = pahs_pkg::STAGE_SLOW;
          refine_count = '0;
        end else begin
          if (!sw.x) begin
            r.step_x = 1'b1;
            away_dirs[0] = 1'b0;
          end else begin
            found_axes[0] = 1'b1;
          end
          if (two_x) begin
            if (!sw.x2) begin
              r.step_x2 = 1'b1;
              away_dirs[0] = 1'b0;
            end else begin
              found_axes[1] = 1'b1;
            end
          end
          if (!sw.y) begin
            r.step_y = 1'b1;
            away_dirs[1] = 1'b0;
          end else begin
            found_axes[2] = 1'b1;
          end
        end
      end
      pahs_pkg::STAGE_SLOW: begin
        away_dirs = 2'b11;
        r.speed_load = 1'b1;
        if (refine_count < pahs_pkg::BACKOFF_END) begin
          r.speed = pahs_pkg::SPEED_BACKOFF;
          refine_count++;
          r.step_x = 1'b1;
          r.step_x2 = two_x;
          r.step_y = 1'b1;
        end else if (refine_count < pahs_pkg::SEEK_END) begin
          r.speed = pahs_pkg::SPEED_SEEK;
          if (!sw.x) begin
            r.step_x = 1'b1;
            away_dirs[0] = 1'b0;
          end
          if (two_x && !sw.x2) begin
            r.step_x2 = 1'b1;
            away_dirs[0] = 1'b0;
          end
          if (!sw.y) begin
            r.step_y = 1'b1;
            away_dirs[1] = 1'b0;
          end
          if (ends_search(sw)) refine_count = pahs_pkg::SEEK_END;
        end else if (refine_count < pahs_pkg::CLEAR_END) begin
          r.speed = pahs_pkg::SPEED_CLEAR;
          refine_count++;
          r.step_x = 1'b1;
          r.step_x2 = two_x;
          r.step_y = 1'b1;
        end else begin
          r.speed = speed_cfg;
          r.position_load = 1'b1;
          r.new_pos_x = xmax_cfg;
          r.new_pos_y = ymax_cfg;
          home_stage = pahs_pkg::STAGE_HOMED;
        end
      end
      default: begin
      end
    endcase
    r.dir_x_away = away_dirs[0];
    r.dir_y_away = away_dirs[1];
    r.stage = home_stage;
  endtask

  function automatic pahs_pkg::switches_t random_switches(bit keep_searching);
    pahs_pkg::switches_t sw;
    sw = pahs_pkg::switches_t'(3'($urandom_range(0, 7)));
    if (keep_searching && ends_search(sw)) begin
      if ($urandom_range(0, 1)) sw.x = 1'b0;
      else sw.y = 1'b0;
    end
    return sw;
  endfunction

  // sender: bursts of words with random gaps between them
  task automatic send_tick(input pahs_pkg::switches_t sw);
    pahs_pkg::result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    x_at_home <= sw.x;
    x2_at_home <= sw.x2;
    y_at_home <= sw.y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_homing(sw, r);
    tick_results_q.push_back(r);
    sent_ticks++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tick_results_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pahs_pkg::REG_USE_SECOND_X: two_x = data[0];
      pahs_pkg::REG_X_MAX:        xmax_cfg = data;
      pahs_pkg::REG_Y_MAX:        ymax_cfg = data;
      pahs_pkg::REG_HOMED_SPEED:  speed_cfg = data;
      default: begin
      end
    endcase
  endtask

  task automatic run_random_phase(input int n, input bit keep_searching);
    repeat (n) send_tick(random_switches(keep_searching));
  endtask

  task automatic test_fast_directed();
    write_reg(pahs_pkg::REG_USE_SECOND_X, 32'hFFFF_FFFF);
    write_reg(pahs_pkg::REG_X_MAX, 32'hFFFF_FFFF);
    write_reg(pahs_pkg::REG_Y_MAX, 32'h0000_0000);
    write_reg(pahs_pkg::REG_HOMED_SPEED, $urandom);
    // each switch found on its own, then near misses with every flag set
    send_tick(3'b000);
    send_tick(3'b100);
    send_tick(3'b010);
    send_tick(3'b001);
    send_tick(3'b110);
    send_tick(3'b011);
    send_tick(3'b101);
    send_tick(3'b000);
    wait_idle();
    // second x off: its switch is ignored and never stepped
    write_reg(pahs_pkg::REG_USE_SECOND_X, 32'hFFFF_FFFE);
    send_tick(3'b110);
    send_tick(3'b011);
    send_tick(3'b010);
    send_tick(3'b000);
    send_tick(3'b100);
    send_tick(3'b001);
  endtask

  task automatic test_fast_random();
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_reg(pahs_pkg::REG_USE_SECOND_X, ($urandom & ~32'd1) | 32'(p % 2));
      if (p == 2) hold_req = 1'b1;
      run_random_phase(100, 1'b1);
    end
  endtask

  task automatic test_backoff();
    wait_idle();
    write_reg(pahs_pkg::REG_USE_SECOND_X, 32'd1);
    while (home_stage == pahs_pkg::STAGE_FAST) send_tick(3'b111);
    run_random_phase(25, 1'b0);
    wait_idle();
    write_reg(pahs_pkg::REG_USE_SECOND_X, 32'd0);
    run_random_phase(25, 1'b0);
  endtask

  task automatic test_seek_random();
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      write_reg(pahs_pkg::REG_USE_SECOND_X, 32'($urandom_range(0, 1)));
      write_reg(pahs_pkg::REG_X_MAX, $urandom);
      if (p == 4) hold_req = 1'b1;
      run_random_phase(100, 1'b1);
    end
  endtask

  task automatic test_clear_and_finish();
    wait_idle();
    write_reg(pahs_pkg::REG_USE_SECOND_X, 32'd1);
    write_reg(pahs_pkg::REG_X_MAX, 32'h0000_0000);
    write_reg(pahs_pkg::REG_Y_MAX, 32'hFFFF_FFFF);
    write_reg(pahs_pkg::REG_HOMED_SPEED, 32'hFFFF_FFFF);
    send_tick(3'b111);
    while (home_stage != pahs_pkg::STAGE_HOMED) send_tick(random_switches(1'b0));
  endtask

  task automatic test_homed_idle();
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_reg(pahs_pkg::REG_USE_SECOND_X, 32'(p % 2));
      write_reg(pahs_pkg::REG_X_MAX, (p % 2) ? 32'hFFFF_FFFF : 32'h0);
      write_reg(pahs_pkg::REG_Y_MAX, $urandom);
      write_reg(pahs_pkg::REG_HOMED_SPEED, (p % 2) ? 32'h0 : 32'hFFFF_FFFF);
      run_random_phase(120, 1'b0);
    end
  endtask

  // receiver: own stall pattern plus a long hold when asked
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  function automatic void compare_word(pahs_pkg::result_t e);
    if (step_x !== e.step_x) begin
      $error("step_x expected %0d got %0d", e.step_x, step_x);
      errors++;
    end
    if (step_x2 !== e.step_x2) begin
      $error("step_x2 expected %0d got %0d", e.step_x2, step_x2);
      errors++;
    end
    if (step_y !== e.step_y) begin
      $error("step_y expected %0d got %0d", e.step_y, step_y);
      errors++;
    end
    if (dir_x_away !== e.dir_x_away) begin
      $error("dir_x_away expected %0d got %0d", e.dir_x_away, dir_x_away);
      errors++;
    end
    if (dir_y_away !== e.dir_y_away) begin
      $error("dir_y_away expected %0d got %0d", e.dir_y_away, dir_y_away);
      errors++;
    end
    if (speed_load !== e.speed_load) begin
      $error("speed_load expected %0d got %0d", e.speed_load, speed_load);
      errors++;
    end
    if (speed !== e.speed) begin
      $error("speed expected %h got %h", e.speed, speed);
      errors++;
    end
    if (position_load !== e.position_load) begin
      $error("position_load expected %0d got %0d", e.position_load, position_load);
      errors++;
    end
    if (new_pos_x !== e.new_pos_x) begin
      $error("new_pos_x expected %h got %h", e.new_pos_x, new_pos_x);
      errors++;
    end
    if (new_pos_y !== e.new_pos_y) begin
      $error("new_pos_y expected %h got %h", e.new_pos_y, new_pos_y);
      errors++;
    end
    if (stage !== e.stage) begin
      $error("stage expected %0d got %0d", e.stage, stage);
      errors++;
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (tick_results_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        compare_word(tick_results_q.pop_front());
        checked_words++;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no word moving", WATCHDOG_LIMIT);
      $display("plotter_axis_homing_sequencer_unit: mismatch");
      $finish;
    end
  end

  initial begin
    two_x = 1'b0;
    xmax_cfg = '0;
    ymax_cfg = '0;
    speed_cfg = '0;
    found_axes = '0;
    home_stage = pahs_pkg::STAGE_FAST;
    refine_count = '0;
    away_dirs = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fast_directed();
    test_fast_random();
    test_backoff();
    test_seek_random();
    test_clear_and_finish();
    test_homed_idle();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d ticks sent: %0d fast seek, %0d slow refine, %0d after homing",
             sent_ticks, stage_ticks[pahs_pkg::STAGE_FAST],
             stage_ticks[pahs_pkg::STAGE_SLOW], stage_ticks[pahs_pkg::STAGE_HOMED]);
    $display("%0d result words checked, %0d field errors", checked_words, errors);
    if (errors == 0) begin
      $display("plotter_axis_homing_sequencer_unit: match");
    end else begin
      $display("plotter_axis_homing_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pahs_pkg.sv
rtl/pahs_step.sv
rtl/plotter_axis_homing_sequencer_unit.sv
rtl/pahs_checker.sv
tb/tb_top.sv
